>>> hw/rtl/lbsc_pkg.sv
// shared types and constants for the lamp blink state classifier
package lbsc_pkg;

    // width of the delay configuration registers in ms
    localparam int DELAY_W = 15;
    // width of the millisecond timestamp
    localparam int TIME_W  = 32;
    // width of the configuration register index
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_DELAY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_DELAY    = 2'd2;

    // lamp class
    typedef enum logic [1:0] {
        LS_OFF     = 2'd0,
        LS_ON      = 2'd1,
        LS_BLINK   = 2'd2,
        LS_UNCLEAR = 2'd3
    } t_lamp_state;

    // one lamp sample
    typedef struct packed {
        logic              lamp_level;
        logic [TIME_W-1:0] now_ms;
    } t_in_item;

    // one classification result
    typedef struct packed {
        logic [1:0] lamp_state;
        logic       filtered_on;
    } t_out_item;

    // filter outcome and delay checks handed to the classifier
    typedef struct packed {
        logic on;
        logic on_expired;
        logic off_expired;
    } t_cls_ctrl;

endpackage

>>> hw/rtl/lbsc_classifier.sv
// four-state lamp classifier state machine
module lbsc_classifier (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  lbsc_pkg::t_cls_ctrl i_ctrl,
    output logic [1:0]         o_lamp_state
);

    lbsc_pkg::t_lamp_state r_state;
    lbsc_pkg::t_lamp_state n_state;

    // state register, moves once per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lbsc_pkg::LS_OFF;
        end else if (i_advance) begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lbsc_pkg::LS_OFF: begin
                if (i_ctrl.on) n_state = lbsc_pkg::LS_UNCLEAR;
            end
            lbsc_pkg::LS_ON: begin
                if (!i_ctrl.on) n_state = lbsc_pkg::LS_OFF;
            end
            lbsc_pkg::LS_BLINK: begin
                if (i_ctrl.on && i_ctrl.on_expired) begin
                    n_state = lbsc_pkg::LS_ON;
                end else if (!i_ctrl.on && i_ctrl.off_expired) begin
                    n_state = lbsc_pkg::LS_OFF;
                end
            end
            lbsc_pkg::LS_UNCLEAR: begin
                if (i_ctrl.on) n_state = lbsc_pkg::LS_BLINK;
            end
            default: begin
                n_state = lbsc_pkg::LS_OFF;
            end
        endcase
    end

    // result carries the class after this sample
    always_comb begin
        o_lamp_state = n_state;
    end

endmodule

>>> hw/rtl/lamp_blink_state_classifier_top.sv
// top level of the lamp blink state classifier
// path: a sample passes through the input register, then the result register
// throughput: one sample per cycle, no bubbles while the output is taken
// the rate is set by the combinational filter and the classifier state update
// reset: synchronous active-low clears delays, timestamps and class to off
module lamp_blink_state_classifier_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // sample channel
    input  logic                                  i_in_valid,
    input  lbsc_pkg::t_in_item                    i_in_data,
    output logic                                  o_in_stall,
    // result channel
    output logic                                  o_out_valid,
    output lbsc_pkg::t_out_item                   o_out_data,
    input  logic                                  i_out_stall,
    // configuration channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [lbsc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lbsc_pkg::DELAY_W-1:0]          i_cfg_data
);

    localparam int PAD_W = lbsc_pkg::TIME_W - lbsc_pkg::DELAY_W;

    logic [lbsc_pkg::DELAY_W-1:0] r_filter_delay;
    logic [lbsc_pkg::DELAY_W-1:0] r_on_delay;
    logic [lbsc_pkg::DELAY_W-1:0] r_off_delay;

    logic                         r_in_valid;
    lbsc_pkg::t_in_item           r_in_data;
    logic                         r_out_valid;
    lbsc_pkg::t_out_item          r_out_data;

    logic [lbsc_pkg::TIME_W-1:0]  r_last_high;
    logic [lbsc_pkg::TIME_W-1:0]  r_last_off;

    logic                         out_advance;
    logic                         in_advance;
    logic                         step;
    logic [lbsc_pkg::TIME_W-1:0]  since_high;
    logic [lbsc_pkg::TIME_W-1:0]  since_off;
    logic                         off_read;
    lbsc_pkg::t_cls_ctrl          cls_ctrl;
    logic [1:0]                   cls_state;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_delay <= '0;
            r_on_delay     <= '0;
            r_off_delay    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lbsc_pkg::CFG_FILTER_DELAY: r_filter_delay <= i_cfg_data;
                lbsc_pkg::CFG_ON_DELAY:     r_on_delay     <= i_cfg_data;
                lbsc_pkg::CFG_OFF_DELAY:    r_off_delay    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // pipeline flow control
    assign out_advance = !r_out_valid || !i_out_stall;
    assign in_advance  = !r_in_valid || out_advance;
    assign step        = r_in_valid && out_advance;
    assign o_in_stall  = !in_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_advance) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_advance && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    // pulse filter and elapsed-time checks, differences wrap
    always_comb begin
        since_high           = r_in_data.now_ms - r_last_high;
        since_off            = r_in_data.now_ms - r_last_off;
        off_read             = !r_in_data.lamp_level
                               && (since_high > {{PAD_W{1'b0}}, r_filter_delay});
        cls_ctrl.on          = !off_read;
        cls_ctrl.on_expired  = since_off > {{PAD_W{1'b0}}, r_on_delay};
        cls_ctrl.off_expired = since_high > {{PAD_W{1'b0}}, r_off_delay};
    end

    // timestamps of the last high sample and the last off reading
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_high <= '0;
            r_last_off  <= '0;
        end else if (step) begin
            if (r_in_data.lamp_level) begin
                r_last_high <= r_in_data.now_ms;
            end
            if (off_read) begin
                r_last_off <= r_in_data.now_ms;
            end
        end
    end

    lbsc_classifier u_classifier (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (step),
        .i_ctrl       (cls_ctrl),
        .o_lamp_state (cls_state)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data.lamp_state  <= cls_state;
            r_out_data.filtered_on <= cls_ctrl.on;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // an off reading never leaves the lamp classed as on
    a_off_not_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_data.filtered_on)
            |-> (r_out_data.lamp_state != lbsc_pkg::LS_ON))
        else $error("off reading with lamp classed on");

    // an on reading never leaves the lamp classed as off
    a_on_not_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.filtered_on)
            |-> (r_out_data.lamp_state != lbsc_pkg::LS_OFF))
        else $error("on reading with lamp classed off");

    // a high sample records its timestamp
    a_high_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_in_data.lamp_level)
            |=> (r_last_high == $past(r_in_data.now_ms)))
        else $error("last high time not updated");

    // a processed sample always lands in the result register
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("processed sample lost");

endmodule
